// ===== hdl/mbd_pkg.sv =====
package mbd_pkg;

   // storage default
   localparam int MBD_NUM_BUTTONS_DEFAULT = 4;

   // field widths
   localparam int LOCKOUT_W   = 16;
   localparam int MASK_W      = 4;
   localparam int IDX_W       = 2;
   localparam int LEVELS_W    = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT_TICKS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED_MASK  = 1'd1;

   // register reset values
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_TICKS_RESET = 16'd50;
   localparam logic [MASK_W-1:0]    ENABLED_MASK_RESET  = 4'd0;

   // request commands
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // event kinds
   localparam logic KIND_PRESS   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // control from the top level to one button cell
   typedef struct packed {
      logic                 go;
      logic                 tick;
      logic                 edge_hit;
      logic                 level;
      logic                 level_now;
      logic                 enabled;
      logic [LOCKOUT_W-1:0] lockout_ticks;
   } btn_ctrl_type;

   // report from one button cell
   typedef struct packed {
      logic fire;
      logic is_release;
   } btn_rpt_type;

endpackage

// ===== hdl/multi_button_debounce_fsm_unit.sv =====
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall command, button_index, level, levels_now
// rsp_      out        rsp_valid/rsp_stall event_button, event_kind
// csr_      in         csr_write_enable    csr_index, csr_write_data
//
// One request per cycle sustained unless a reporting request is held by rsp_stall.
// A request is registered in the input register, then updates the per-button
// state and, for a reported edge, loads the output register.
// Reset (synchronous): every button up with a zero counter, lockout 50,
// all buttons disabled, both registers empty.
// rsp_stall holds the response; only a request that would report is held
// behind it, ticks and ignored edges still pass.
module multi_button_debounce_fsm_unit #(
   parameter int NUM_BUTTONS = mbd_pkg::MBD_NUM_BUTTONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [mbd_pkg::IDX_W-1:0]       req_button_index,
   input  logic                            req_level,
   input  logic [mbd_pkg::LEVELS_W-1:0]    req_levels_now,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mbd_pkg::IDX_W-1:0]       rsp_event_button,
   output logic                            rsp_event_kind,
   // register write port
   input  logic                            csr_write_enable,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import mbd_pkg::*;

   // configuration registers
   logic [LOCKOUT_W-1:0] lockout_ticks_ff;
   logic [MASK_W-1:0]    enabled_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_TICKS_RESET;
         enabled_mask_ff  <= ENABLED_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOCKOUT_TICKS: lockout_ticks_ff <= csr_write_data[LOCKOUT_W-1:0];
            CSR_ENABLED_MASK:  enabled_mask_ff  <= csr_write_data[MASK_W-1:0];
            default: begin
               lockout_ticks_ff <= lockout_ticks_ff;
               enabled_mask_ff  <= enabled_mask_ff;
            end
         endcase
      end
   end

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_cmd_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic                s1_level_ff;
   logic [LEVELS_W-1:0] s1_levels_ff;

   logic                   req_accept;
   logic                   s1_go;
   logic                   any_fire;
   logic                   fire_kind;
   logic                   rsp_space;
   logic [NUM_BUTTONS-1:0] fire_vec;
   logic [NUM_BUTTONS-1:0] kind_vec;

   // a reporting request waits for room in the output register
   assign s1_go      = s1_valid_ff && (!any_fire || rsp_space);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff    <= req_command;
         s1_idx_ff    <= req_button_index;
         s1_level_ff  <= req_level;
         s1_levels_ff <= req_levels_now;
      end
   end

   // one cell per button; buttons past the mask width stay disabled
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      btn_ctrl_type ctrl;
      btn_rpt_type  rpt;
      logic         edge_hit_w;
      logic         level_now_w;
      logic         enabled_w;

      if (i < MASK_W) begin : g_wired
         assign edge_hit_w  = (s1_cmd_ff == CMD_EDGE) && (s1_idx_ff == IDX_W'(i));
         assign level_now_w = s1_levels_ff[i];
         assign enabled_w   = enabled_mask_ff[i];
      end else begin : g_unwired
         assign edge_hit_w  = 1'b0;
         assign level_now_w = 1'b0;
         assign enabled_w   = 1'b0;
      end

      always_comb begin
         ctrl.go            = s1_go;
         ctrl.tick          = (s1_cmd_ff == CMD_TICK);
         ctrl.edge_hit      = edge_hit_w;
         ctrl.level         = s1_level_ff;
         ctrl.level_now     = level_now_w;
         ctrl.enabled       = enabled_w;
         ctrl.lockout_ticks = lockout_ticks_ff;
      end

      mbd_button u_button (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .rpt   (rpt)
      );

      assign fire_vec[i] = rpt.fire;
      assign kind_vec[i] = rpt.is_release;
   end

   // at most one cell fires, so an OR picks its kind
   assign any_fire  = |fire_vec;
   assign fire_kind = (|(fire_vec & kind_vec)) ? KIND_RELEASE : KIND_PRESS;

   mbd_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (s1_go && any_fire),
      .load_button      (s1_idx_ff),
      .load_kind        (fire_kind),
      .space            (rsp_space),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind)
   );

   // only an edge request can report
   a_fire_is_edge: assert property (@(posedge clock) disable iff (reset)
      any_fire |-> (s1_valid_ff || !s1_go) && s1_cmd_ff == CMD_EDGE)
      else $error("tick request reported an event");

   // at most one button reports per request
   a_single_fire: assert property (@(posedge clock) disable iff (reset)
      $onehot0(fire_vec))
      else $error("more than one button reported");

   // a held response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !(s1_go && any_fire))
      else $error("held response overwritten");

   // a request held in the input register stays until it moves on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_idx_ff) && $stable(s1_cmd_ff))
      else $error("stalled request lost");

endmodule

// ===== hdl/mbd_button.sv =====
module mbd_button (
   input  logic                 clock,
   input  logic                 reset,
   input  mbd_pkg::btn_ctrl_type ctrl,
   output mbd_pkg::btn_rpt_type  rpt
);
   import mbd_pkg::*;

   typedef enum logic [1:0] {
      MODE_UP         = 2'd0,
      MODE_DOWN       = 2'd1,
      MODE_DEBOUNCING = 2'd2
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [LOCKOUT_W-1:0] count_ff, count_in;

   // reported edge: up with press level, or down with release level
   always_comb begin
      rpt.fire = ctrl.edge_hit && ctrl.enabled &&
                 ((mode_ff == MODE_UP && ctrl.level) ||
                  (mode_ff == MODE_DOWN && !ctrl.level));
      rpt.is_release = (mode_ff == MODE_DOWN);
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (ctrl.go) begin
         if (rpt.fire) begin
            mode_in  = MODE_DEBOUNCING;
            count_in = ctrl.lockout_ticks;
         end else if (ctrl.tick && ctrl.enabled) begin
            case (mode_ff)
               MODE_DEBOUNCING: begin
                  if (count_ff <= LOCKOUT_W'(1)) begin
                     count_in = '0;
                     mode_in  = ctrl.level_now ? MODE_DOWN : MODE_UP;
                  end else begin
                     count_in = count_ff - LOCKOUT_W'(1);
                  end
               end
               default: begin
                  mode_in  = mode_ff;
                  count_in = count_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_UP;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/mbd_rsp_reg.sv =====
module mbd_rsp_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [mbd_pkg::IDX_W-1:0] load_button,
   input  logic                      load_kind,
   output logic                      space,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [mbd_pkg::IDX_W-1:0] rsp_event_button,
   output logic                      rsp_event_kind
);
   import mbd_pkg::*;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] button_ff;
   logic             kind_ff;

   // free, or emptying this cycle
   assign space = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         button_ff <= load_button;
         kind_ff   <= load_kind;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_button = button_ff;
   assign rsp_event_kind   = kind_ff;

endmodule
